/* hdl/a51_pkg.sv */
// Shared constants, types and a helper function for the A5/1 burst keystream unit.
package a51_pkg;

    // Burst and word geometry.
    localparam int BURST_BITS   = 114;
    localparam int WORD_BITS    = 32;
    localparam int MAX_WORDS    = 4;
    localparam int NWORDS_RAW   = (BURST_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int NWORDS       = (NWORDS_RAW > MAX_WORDS) ? MAX_WORDS : NWORDS_RAW;
    localparam int KEEP_RAW     = NWORDS * WORD_BITS;
    localparam int KEEP_BITS    = (KEEP_RAW > BURST_BITS) ? BURST_BITS : KEEP_RAW;

    // Field widths.
    localparam int KEY_W        = 64;
    localparam int COUNT_W      = 22;
    localparam int MODE_W       = 2;
    localparam int KSW_W        = 32;
    localparam int WIDX_W       = 2;
    localparam int VBITS_W      = 6;
    localparam int CFG_IDX_W    = 1;
    localparam int FILL_W       = $clog2(WORD_BITS + 1);
    localparam int BITPOS_W     = $clog2(WORD_BITS);

    // Sequence lengths.
    localparam int MIX_STEPS    = KEY_W + COUNT_W;
    localparam int WARMUP_STEPS = 100;
    localparam int TOTAL_BITS   = 2 * BURST_BITS;
    localparam int STEP_W       = 8;

    // LFSR lengths and feedback taps.
    localparam int LA_W = 19;
    localparam int LB_W = 22;
    localparam int LC_W = 23;
    localparam logic [LA_W-1:0] LA_TAPS = 19'h72000;
    localparam logic [LB_W-1:0] LB_TAPS = 22'h300000;
    localparam logic [LC_W-1:0] LC_TAPS = 23'h700080;

    // Clocking bits for the majority rule.
    localparam int LA_CLK = 8;
    localparam int LB_CLK = 10;
    localparam int LC_CLK = 10;

    // Algorithm codes and register indexes.
    localparam logic [MODE_W-1:0]    MODE_OFF = 2'd0;
    localparam logic [MODE_W-1:0]    MODE_A51 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX,
        ST_WARM,
        ST_GEN,
        ST_FLAG
    } seq_state_t;

    // Commands from the sequencer to the LFSR core.
    typedef struct packed {
        logic clear;
        logic mix_en;
        logic mix_bit;
        logic maj_en;
    } lfsr_ctrl_t;

    // Requests from the sequencer to the word packer.
    typedef struct packed {
        logic bit_valid;
        logic bit_value;
        logic flag_valid;
    } pack_ctrl_t;

    // Status from the word packer back to the sequencer.
    typedef struct packed {
        logic bit_ready;
        logic flag_ready;
    } pack_stat_t;

    // Number of keystream bits carried by word k of a burst.
    function automatic logic [VBITS_W-1:0] word_bits(input logic [WIDX_W-1:0] k);
        int remaining;
        remaining = BURST_BITS - int'(k) * WORD_BITS;
        if (remaining > WORD_BITS)
            remaining = WORD_BITS;
        return VBITS_W'(remaining);
    endfunction

endpackage

/* hdl/a51_req_if.sv */
// Burst request channel: frame count and link direction.
interface a51_req_if;
    logic                           valid;
    logic                           ready;
    logic [a51_pkg::COUNT_W-1:0]    frame_count;
    logic                           uplink;

    modport source (output valid, frame_count, uplink, input ready);
    modport sink   (input valid, frame_count, uplink, output ready);
endinterface

/* hdl/a51_word_if.sv */
// Keystream word channel: one packed word of the burst keystream per beat.
interface a51_word_if;
    logic                           valid;
    logic                           ready;
    logic [a51_pkg::KSW_W-1:0]      keystream_word;
    logic [a51_pkg::WIDX_W-1:0]     word_index;
    logic [a51_pkg::VBITS_W-1:0]    valid_bits;
    logic                           last;
    logic                           unsupported;

    modport source (output valid, keystream_word, word_index, valid_bits, last, unsupported,
                    input ready);
    modport sink   (input valid, keystream_word, word_index, valid_bits, last, unsupported,
                    output ready);
endinterface

/* hdl/a51_lfsr.sv */
// The three A5/1 shift registers with linear mixing and majority clocking.
module a51_lfsr
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  a51_pkg::lfsr_ctrl_t   ctrl,
    output logic                  ks_bit
);

    logic [a51_pkg::LA_W-1:0] a_reg, a_next, a_step;
    logic [a51_pkg::LB_W-1:0] b_reg, b_next, b_step;
    logic [a51_pkg::LC_W-1:0] c_reg, c_next, c_step;
    logic x_bit, y_bit, z_bit, maj_bit;

    // One regular clocking of each register.
    assign a_step = {a_reg[a51_pkg::LA_W-2:0], ^(a_reg & a51_pkg::LA_TAPS)};
    assign b_step = {b_reg[a51_pkg::LB_W-2:0], ^(b_reg & a51_pkg::LB_TAPS)};
    assign c_step = {c_reg[a51_pkg::LC_W-2:0], ^(c_reg & a51_pkg::LC_TAPS)};

    // Majority vote over the clocking bits.
    assign x_bit   = a_reg[a51_pkg::LA_CLK];
    assign y_bit   = b_reg[a51_pkg::LB_CLK];
    assign z_bit   = c_reg[a51_pkg::LC_CLK];
    assign maj_bit = (x_bit & y_bit) | (x_bit & z_bit) | (y_bit & z_bit);

    // Next state: clear, mix one input bit, or step the registers that agree.
    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        if (ctrl.clear)
        begin
            a_next = '0;
            b_next = '0;
            c_next = '0;
        end
        else if (ctrl.mix_en)
        begin
            a_next = a_step ^ {{(a51_pkg::LA_W-1){1'b0}}, ctrl.mix_bit};
            b_next = b_step ^ {{(a51_pkg::LB_W-1){1'b0}}, ctrl.mix_bit};
            c_next = c_step ^ {{(a51_pkg::LC_W-1){1'b0}}, ctrl.mix_bit};
        end
        else if (ctrl.maj_en)
        begin
            if (x_bit == maj_bit)
                a_next = a_step;
            if (y_bit == maj_bit)
                b_next = b_step;
            if (z_bit == maj_bit)
                c_next = c_step;
        end
    end

    // Keystream bit taken from the state after this step.
    assign ks_bit = a_next[a51_pkg::LA_W-1] ^ b_next[a51_pkg::LB_W-1] ^ c_next[a51_pkg::LC_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
            c_reg <= '0;
        end
        else
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
        end
    end

endmodule

/* hdl/a51_pack.sv */
// Collects keystream bits into words and holds the outgoing beat in a register.
module a51_pack
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  a51_pkg::pack_ctrl_t   ctrl,
    output a51_pkg::pack_stat_t   stat,
    a51_word_if.source            ks
);

    logic [a51_pkg::KSW_W-1:0]   acc_reg, acc_next;
    logic [a51_pkg::FILL_W-1:0]  fill_reg, fill_next;
    logic [a51_pkg::WIDX_W-1:0]  widx_reg, widx_next;
    logic                        full_reg, full_next;

    logic                        out_valid_reg, out_valid_next;
    logic [a51_pkg::KSW_W-1:0]   out_word_reg, out_word_next;
    logic [a51_pkg::WIDX_W-1:0]  out_widx_reg, out_widx_next;
    logic [a51_pkg::VBITS_W-1:0] out_vbits_reg, out_vbits_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_unsup_reg, out_unsup_next;

    logic [a51_pkg::VBITS_W-1:0] cur_bits;
    logic                        cur_last;
    logic                        out_free;
    logic                        bit_take;
    logic                        word_move;
    logic                        flag_take;

    assign cur_bits  = a51_pkg::word_bits(widx_reg);
    assign cur_last  = (widx_reg == a51_pkg::WIDX_W'(a51_pkg::NWORDS - 1));
    assign out_free  = !out_valid_reg || ks.ready;

    assign stat.bit_ready  = !full_reg;
    assign stat.flag_ready = !full_reg && (fill_reg == '0) && out_free;

    assign bit_take  = ctrl.bit_valid && !full_reg;
    assign word_move = full_reg && out_free;
    assign flag_take = ctrl.flag_valid && stat.flag_ready;

    // Word assembly and hand-over to the output register.
    always_comb
    begin
        acc_next       = acc_reg;
        fill_next      = fill_reg;
        widx_next      = widx_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_widx_next  = out_widx_reg;
        out_vbits_next = out_vbits_reg;
        out_last_next  = out_last_reg;
        out_unsup_next = out_unsup_reg;

        if (ks.ready)
            out_valid_next = 1'b0;

        if (bit_take)
        begin
            acc_next[fill_reg[a51_pkg::BITPOS_W-1:0]] = ctrl.bit_value;
            fill_next = fill_reg + 1'b1;
            if (a51_pkg::VBITS_W'(fill_reg) + 1'b1 == cur_bits)
                full_next = 1'b1;
        end

        if (word_move)
        begin
            out_valid_next = 1'b1;
            out_word_next  = acc_reg;
            out_widx_next  = widx_reg;
            out_vbits_next = cur_bits;
            out_last_next  = cur_last;
            out_unsup_next = 1'b0;
            acc_next       = '0;
            fill_next      = '0;
            full_next      = 1'b0;
            widx_next      = cur_last ? '0 : widx_reg + 1'b1;
        end
        else if (flag_take)
        begin
            out_valid_next = 1'b1;
            out_word_next  = '0;
            out_widx_next  = '0;
            out_vbits_next = '0;
            out_last_next  = 1'b1;
            out_unsup_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            fill_reg      <= '0;
            widx_reg      <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            fill_reg      <= fill_next;
            widx_reg      <= widx_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload carries no reset.
    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        out_widx_reg  <= out_widx_next;
        out_vbits_reg <= out_vbits_next;
        out_last_reg  <= out_last_next;
        out_unsup_reg <= out_unsup_next;
    end

    assign ks.valid          = out_valid_reg;
    assign ks.keystream_word = out_word_reg;
    assign ks.word_index     = out_widx_reg;
    assign ks.valid_bits     = out_vbits_reg;
    assign ks.last           = out_last_reg;
    assign ks.unsupported    = out_unsup_reg;

endmodule

/* hdl/a5_1_burst_keystream_unit.sv */
// Top level of the A5/1 burst keystream unit: sequencer, configuration and assertions.
//
// One burst request is taken at a time. With A5/1 or no ciphering selected, a request is
// accepted, the key and frame count are mixed in, the registers are warmed up under majority
// clocking and then one bit is generated per cycle unless a kept bit must wait: 114 bits for
// downlink, 228 for uplink. When one of the first three words is full, the next kept bit
// waits while that word moves to the output register, and also while a finished word waits
// for the result side to take the one before it. The three LFSRs produce the keystream bits,
// and the kept ones go into the word packer. No ciphering runs the same sequence and returns
// all-zero words. An unsupported mode gives one flagged beat once the packer is empty and its
// output register is free. The packer's output register lets the last words of a burst
// drain while the next request is accepted.
module a5_1_burst_keystream_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [a51_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [a51_pkg::KEY_W-1:0]         cfg_data,
    a51_req_if.sink                           req,
    a51_word_if.source                        ks
);

    localparam int SR_W = a51_pkg::MIX_STEPS;

    logic [a51_pkg::KEY_W-1:0]    cipher_key_reg;
    logic [a51_pkg::MODE_W-1:0]   algorithm_mode_reg;

    a51_pkg::seq_state_t          state_reg, state_next;
    logic [a51_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [SR_W-1:0]              mix_sr_reg, mix_sr_next;
    logic                         uplink_reg, uplink_next;

    a51_pkg::lfsr_ctrl_t          lfsr_ctrl;
    a51_pkg::pack_ctrl_t          pack_ctrl;
    a51_pkg::pack_stat_t          pack_stat;
    logic                         ks_bit;

    logic [a51_pkg::STEP_W-1:0]   gen_first;
    logic [a51_pkg::STEP_W-1:0]   gen_final;
    logic                         keep_bit;
    logic                         mode_ok;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_key_reg     <= '0;
            algorithm_mode_reg <= a51_pkg::MODE_OFF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                a51_pkg::CFG_KEY:  cipher_key_reg     <= cfg_data;
                a51_pkg::CFG_MODE: algorithm_mode_reg <= cfg_data[a51_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign mode_ok = algorithm_mode_reg inside {a51_pkg::MODE_OFF, a51_pkg::MODE_A51};

    // Window of generated bits kept for the chosen direction.
    assign gen_first = uplink_reg ? a51_pkg::STEP_W'(a51_pkg::BURST_BITS) : '0;
    assign gen_final = gen_first + a51_pkg::STEP_W'(a51_pkg::KEEP_BITS - 1);
    assign keep_bit  = (step_reg >= gen_first) && (step_reg <= gen_final);

    // Sequencer: next state and commands to the LFSR core and the packer.
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        mix_sr_next = mix_sr_reg;
        uplink_next = uplink_reg;
        req.ready   = 1'b0;
        lfsr_ctrl   = '0;
        pack_ctrl   = '0;

        case (state_reg)
            a51_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    uplink_next = req.uplink;
                    step_next   = '0;
                    if (mode_ok)
                    begin
                        lfsr_ctrl.clear = 1'b1;
                        mix_sr_next     = {req.frame_count, cipher_key_reg};
                        state_next      = a51_pkg::ST_MIX;
                    end
                    else
                    begin
                        state_next = a51_pkg::ST_FLAG;
                    end
                end
            end

            a51_pkg::ST_MIX:
            begin
                lfsr_ctrl.mix_en  = 1'b1;
                lfsr_ctrl.mix_bit = mix_sr_reg[0];
                mix_sr_next       = {1'b0, mix_sr_reg[SR_W-1:1]};
                if (step_reg == a51_pkg::STEP_W'(a51_pkg::MIX_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = a51_pkg::ST_WARM;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end

            a51_pkg::ST_WARM:
            begin
                lfsr_ctrl.maj_en = 1'b1;
                if (step_reg == a51_pkg::STEP_W'(a51_pkg::WARMUP_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = a51_pkg::ST_GEN;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end

            a51_pkg::ST_GEN:
            begin
                // A kept bit waits while the packer holds a complete word.
                if (!keep_bit || pack_stat.bit_ready)
                begin
                    lfsr_ctrl.maj_en    = 1'b1;
                    pack_ctrl.bit_valid = keep_bit;
                    pack_ctrl.bit_value = ks_bit && (algorithm_mode_reg == a51_pkg::MODE_A51);
                    step_next           = step_reg + 1'b1;
                    if (step_reg == gen_final)
                        state_next = a51_pkg::ST_IDLE;
                end
            end

            a51_pkg::ST_FLAG:
            begin
                pack_ctrl.flag_valid = 1'b1;
                if (pack_stat.flag_ready)
                    state_next = a51_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = a51_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= a51_pkg::ST_IDLE;
            step_reg   <= '0;
            uplink_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            uplink_reg <= uplink_next;
        end
    end

    // Key and count shift register carries no reset.
    always_ff @(posedge clk)
    begin
        mix_sr_reg <= mix_sr_next;
    end

    a51_lfsr u_lfsr
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (lfsr_ctrl),
        .ks_bit (ks_bit)
    );

    a51_pack u_pack
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (pack_ctrl),
        .stat  (pack_stat),
        .ks    (ks)
    );

    // A keystream bit is only offered when the packer can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        pack_ctrl.bit_valid |-> pack_stat.bit_ready)
    else $error("keystream bit offered while the packer is full");

    // The LFSR core is never told to majority-step in the same cycle as it mixes or clears.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(lfsr_ctrl.mix_en && lfsr_ctrl.maj_en) && !(lfsr_ctrl.clear && lfsr_ctrl.maj_en))
    else $error("conflicting LFSR commands");

    // A flagged beat is always the only and final beat of its request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ks.valid && ks.unsupported) |-> (ks.last && ks.valid_bits == '0))
    else $error("unsupported beat without last or with data bits");

    // The final keystream beat of a burst sits at the last word position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ks.valid && ks.last && !ks.unsupported)
            |-> (ks.word_index == a51_pkg::WIDX_W'(a51_pkg::NWORDS - 1)))
    else $error("last keystream beat at the wrong word position");

endmodule
